// ===== design/tsle_pkg.sv =====
`timescale 1ns / 1ps

package tsle_pkg;

    localparam int unsigned LINE_CAP_DEF = 256;

    typedef enum logic [2:0] {
        K_INSERT    = 3'd0,
        K_OVERWRITE = 3'd1,
        K_RIGHT     = 3'd2,
        K_LEFT      = 3'd3,
        K_END       = 3'd4,
        K_HOME      = 3'd5,
        K_ERASE_L   = 3'd6,
        K_ERASE_R   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_MOVE
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_in;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [8:0] left_count;
        logic [8:0] right_count;
    } rsp_t;

endpackage

// ===== design/two_stack_line_editor.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_ready  tsle_pkg::cmd_t (kind, char_in)
// rsp       out        rsp_valid / rsp_ready  tsle_pkg::rsp_t (status, left_count, right_count)
//
// Insert, overwrite, erase and any ignored or rejected command complete without entering S_MOVE.
// Cursor right/left go through a registered stack read, then the write.
// End/home repeat the read and write for every character moved; read and write overlap.
// Reset clears both depths and the state machine; stack entries are not cleared.
// A command is taken only while the result register is empty or draining,
// so a stalled result holds off the next command.

module two_stack_line_editor #(
    parameter int unsigned LINE_CAP = tsle_pkg::LINE_CAP_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  tsle_pkg::cmd_t   cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tsle_pkg::rsp_t   rsp
);

    localparam int unsigned CW = $clog2(LINE_CAP + 1);
    localparam int unsigned AW = $clog2(LINE_CAP);

    // stacks: one byte per entry, registered read
    logic [7:0] left_mem  [LINE_CAP];
    logic [7:0] right_mem [LINE_CAP];

    tsle_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    ld_reg, ld_next;
    logic [CW-1:0]    rd_reg, rd_next;
    logic             dir_reg, dir_next;      // 1: right stack to left stack
    logic             walk_reg, walk_next;    // move the whole stack
    logic             rsp_valid_reg, rsp_valid_next;
    tsle_pkg::rsp_t   rsp_reg, rsp_next;

    logic [7:0]       l_rdata_reg, r_rdata_reg;
    logic             l_we, r_we, l_re, r_re;
    logic [AW-1:0]    l_wa, r_wa, l_ra, r_ra;
    logic [7:0]       l_wd, r_wd;

    logic             accept;
    logic             finish;
    logic             full;
    logic [CW:0]      total;
    tsle_pkg::status_t status;

    function automatic logic [8:0] to_count(input logic [CW-1:0] d);
        logic [CW+8:0] w;
        w = (CW+9)'(d);
        return w[8:0];
    endfunction

    assign total     = (CW+1)'(ld_reg) + (CW+1)'(rd_reg);
    assign full      = total >= (CW+1)'(LINE_CAP);
    assign cmd_ready = (state_reg == tsle_pkg::S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        ld_next        = ld_reg;
        rd_next        = rd_reg;
        dir_next       = dir_reg;
        walk_next      = walk_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        l_we   = 1'b0;
        r_we   = 1'b0;
        l_re   = 1'b0;
        r_re   = 1'b0;
        l_wa   = ld_reg[AW-1:0];
        r_wa   = rd_reg[AW-1:0];
        l_wd   = cmd.char_in;
        r_wd   = l_rdata_reg;
        l_ra   = AW'(ld_reg - 1'b1);
        r_ra   = AW'(rd_reg - 1'b1);
        finish = 1'b0;
        status = tsle_pkg::ST_DONE;

        case (state_reg)
            tsle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    finish = 1'b1;
                    case (cmd.kind)
                        tsle_pkg::K_INSERT:
                        begin
                            if (full)
                            begin
                                status = tsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                l_we    = 1'b1;
                                ld_next = ld_reg + 1'b1;
                            end
                        end
                        tsle_pkg::K_OVERWRITE:
                        begin
                            // replace the character after the cursor; insert at end of line
                            if (rd_reg != '0)
                            begin
                                rd_next = rd_reg - 1'b1;
                                l_we    = 1'b1;
                                ld_next = ld_reg + 1'b1;
                            end
                            else if (full)
                            begin
                                status = tsle_pkg::ST_FULL;
                            end
                            else
                            begin
                                l_we    = 1'b1;
                                ld_next = ld_reg + 1'b1;
                            end
                        end
                        tsle_pkg::K_RIGHT, tsle_pkg::K_END:
                        begin
                            if (rd_reg == '0)
                            begin
                                status = tsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                // fetch the top of the right stack, write it next cycle
                                r_re       = 1'b1;
                                rd_next    = rd_reg - 1'b1;
                                dir_next   = 1'b1;
                                walk_next  = (cmd.kind == tsle_pkg::K_END);
                                state_next = tsle_pkg::S_MOVE;
                                finish     = 1'b0;
                            end
                        end
                        tsle_pkg::K_LEFT, tsle_pkg::K_HOME:
                        begin
                            if (ld_reg == '0)
                            begin
                                status = tsle_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                l_re       = 1'b1;
                                ld_next    = ld_reg - 1'b1;
                                dir_next   = 1'b0;
                                walk_next  = (cmd.kind == tsle_pkg::K_HOME);
                                state_next = tsle_pkg::S_MOVE;
                                finish     = 1'b0;
                            end
                        end
                        tsle_pkg::K_ERASE_L:
                        begin
                            if (ld_reg == '0)
                                status = tsle_pkg::ST_IGNORED;
                            else
                                ld_next = ld_reg - 1'b1;
                        end
                        tsle_pkg::K_ERASE_R:
                        begin
                            if (rd_reg == '0)
                                status = tsle_pkg::ST_IGNORED;
                            else
                                rd_next = rd_reg - 1'b1;
                        end
                        default:
                        begin
                            status = tsle_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            tsle_pkg::S_MOVE:
            begin
                // write the byte read last cycle; in a walk, read the next one alongside
                if (dir_reg)
                begin
                    l_we    = 1'b1;
                    l_wd    = r_rdata_reg;
                    ld_next = ld_reg + 1'b1;
                    if (walk_reg && (rd_reg != '0))
                    begin
                        r_re    = 1'b1;
                        rd_next = rd_reg - 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    r_we    = 1'b1;
                    rd_next = rd_reg + 1'b1;
                    if (walk_reg && (ld_reg != '0))
                    begin
                        l_re    = 1'b1;
                        ld_next = ld_reg - 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                if (finish)
                    state_next = tsle_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tsle_pkg::S_IDLE;
            end
        endcase

        // the result register is empty or draining here, since a command enters only then
        if (finish)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = status;
            rsp_next.left_count  = to_count(ld_next);
            rsp_next.right_count = to_count(rd_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsle_pkg::S_IDLE;
            ld_reg        <= '0;
            rd_reg        <= '0;
            dir_reg       <= 1'b0;
            walk_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ld_reg        <= ld_next;
            rd_reg        <= rd_next;
            dir_reg       <= dir_next;
            walk_reg      <= walk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // left stack memory
    always_ff @(posedge clk)
    begin
        if (l_we)
            left_mem[l_wa] <= l_wd;
        if (l_re)
            l_rdata_reg <= left_mem[l_ra];
    end

    // right stack memory
    always_ff @(posedge clk)
    begin
        if (r_we)
            right_mem[r_wa] <= r_wd;
        if (r_re)
            r_rdata_reg <= right_mem[r_ra];
    end

endmodule
